// ===== hdl/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// SVPWM duty calculator package
// Shared widths, constants, payload structs and cell hand-off structs.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // Angle and duty resolution
  localparam int ANGLE_BITS = 16;
  localparam int DUTY_BITS  = 16;
  localparam int Q30_BITS   = 30;

  // pi/3 in Q30
  localparam int X_W = 31;
  localparam logic [X_W-1:0] PI3_Q30 = 31'd1124419809;

  // Field and register widths
  localparam int ANGLE_IN_W = 16;
  localparam int VOLT_W     = 16;
  localparam int DUTY_W     = 16;
  localparam int SECT_W     = 3;
  localparam int BV_W       = 15;
  localparam int PERIOD_W   = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [BV_W-1:0]     BUS_VOLTAGE_RESET = 15'd16384;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET      = 16'd3600;

  // Magnitude path widths
  localparam int SQ_W       = 31;              // one squared command
  localparam int THREE_W    = 33;              // 3 * (d^2 + q^2)
  localparam int BVSQ_W     = 2 * BV_W;
  localparam int ROOT_IN_W  = 62;              // radicand: 3S in Q32
  localparam int ROOT_RES_W = ROOT_IN_W + 1;
  localparam int ROOT_CELLS = ROOT_IN_W / 2 + 1;
  localparam int ROOT_OUT_W = ROOT_IN_W / 2;
  localparam int ROOT_SHIFT = Q30_BITS - 16;
  localparam int DIV_W      = ROOT_OUT_W + ROOT_SHIFT;
  localparam int DIV_CELLS  = Q30_BITS;

  // Sine series
  localparam int SIN_TERMS   = 5;
  localparam int SUM_W       = X_W + 2;
  localparam int RECIP_SHIFT = 38;
  localparam int RECIP_W     = 36;

  localparam int T_W = 32;

  // Pipeline depths (register stages from the accept edge)
  localparam int MAG_DEPTH   = 3 + ROOT_CELLS + DIV_CELLS;
  localparam int SIN_DEPTH   = 4 + 2 * SIN_TERMS;
  localparam int ALIGN_DEPTH = MAG_DEPTH - SIN_DEPTH;
  localparam int SECT_DEPTH  = MAG_DEPTH - 2;
  localparam int PIPE_DEPTH  = MAG_DEPTH + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUS_VOLTAGE = 1'b0,
    REG_PERIOD      = 1'b1
  } cfg_reg_t;

  typedef enum logic [SECT_W-1:0] {
    SECT_1 = 3'd0,
    SECT_2 = 3'd1,
    SECT_3 = 3'd2,
    SECT_4 = 3'd3,
    SECT_5 = 3'd4,
    SECT_6 = 3'd5
  } sector_t;

  typedef struct packed {
    logic        [ANGLE_IN_W-1:0] elec_angle;
    logic signed [VOLT_W-1:0]     volt_d;
    logic signed [VOLT_W-1:0]     volt_q;
  } svpwm_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic [SECT_W-1:0] sector_num;
  } svpwm_res_t;

  typedef struct packed {
    logic [ROOT_IN_W-1:0]  v;
    logic [ROOT_RES_W-1:0] res;
    logic                  clamp;
  } root_pipe_t;

  typedef struct packed {
    logic [DIV_W-1:0]     rem;
    logic [DIV_CELLS-1:0] quo;
    logic                 clamp;
  } div_pipe_t;

  typedef struct packed {
    logic        [X_W-1:0]   term;
    logic        [X_W-1:0]   x2;
    logic signed [SUM_W-1:0] sum;
  } sin_pipe_t;

endpackage

// ===== hdl/svpwm_root_cell.sv =====
// ----------------------------------------------------------------------------
// SVPWM square root cell
// One digit-pair step of the integer square root; one register stage.
// ----------------------------------------------------------------------------
module svpwm_root_cell #(
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  svpwm_pkg::root_pipe_t  din,
  output svpwm_pkg::root_pipe_t  dout
);
  import svpwm_pkg::*;

  localparam logic [ROOT_RES_W-1:0] BIT = ROOT_RES_W'(1) << (ROOT_IN_W - 2 * IDX);

  logic [ROOT_RES_W-1:0] trial;
  logic                  ge;

  assign trial = din.res + BIT;
  assign ge    = {1'b0, din.v} >= trial;

  always_ff @(posedge clk) begin
    dout.clamp <= din.clamp;
    if (ge) begin
      dout.v   <= din.v - trial[ROOT_IN_W-1:0];
      dout.res <= (din.res >> 1) + BIT;
    end else begin
      dout.v   <= din.v;
      dout.res <= din.res >> 1;
    end
  end

endmodule

// ===== hdl/svpwm_div_cell.sv =====
// ----------------------------------------------------------------------------
// SVPWM divider cell
// One restoring division step: resolves quotient bit IDX.
// ----------------------------------------------------------------------------
module svpwm_div_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic [svpwm_pkg::BV_W-1:0]    divisor,
  input  svpwm_pkg::div_pipe_t          din,
  output svpwm_pkg::div_pipe_t          dout
);
  import svpwm_pkg::*;

  logic [DIV_W-1:0] dsh;
  logic             ge;

  assign dsh = DIV_W'(divisor) << IDX;
  assign ge  = din.rem >= dsh;

  always_ff @(posedge clk) begin
    dout.clamp <= din.clamp;
    if (ge) begin
      dout.rem <= din.rem - dsh;
      dout.quo <= din.quo | (DIV_CELLS'(1) << IDX);
    end else begin
      dout.rem <= din.rem;
      dout.quo <= din.quo;
    end
  end

endmodule

// ===== hdl/svpwm_sin_cell.sv =====
// ----------------------------------------------------------------------------
// SVPWM sine series cell
// Adds one Taylor term of order 2N+1; two register stages.
// ----------------------------------------------------------------------------
module svpwm_sin_cell #(
  parameter int N = 1
) (
  input  logic                  clk,
  input  svpwm_pkg::sin_pipe_t  din,
  output svpwm_pkg::sin_pipe_t  dout
);
  import svpwm_pkg::*;

  localparam longint unsigned DIVISOR = (2 * N) * (2 * N + 1);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);

  logic [2*X_W-1:0]       prod;
  logic [X_W+RECIP_W-1:0] scaled;
  logic [X_W-1:0]         quo;
  sin_pipe_t              mid;

  assign prod   = din.term * din.x2;
  assign scaled = mid.term * RECIP;
  assign quo    = X_W'(scaled >> RECIP_SHIFT);

  // previous term times x^2
  always_ff @(posedge clk) begin
    mid.term <= X_W'(prod >> Q30_BITS);
    mid.x2   <= din.x2;
    mid.sum  <= din.sum;
  end

  // divide by (2N)(2N+1) and accumulate with alternating sign
  always_ff @(posedge clk) begin
    dout.term <= quo;
    dout.x2   <= mid.x2;
    if (N % 2 == 1) begin
      dout.sum <= mid.sum - $signed({{(SUM_W-X_W){1'b0}}, quo});
    end else begin
      dout.sum <= mid.sum + $signed({{(SUM_W-X_W){1'b0}}, quo});
    end
  end

endmodule

// ===== hdl/svpwm_delay.sv =====
// ----------------------------------------------------------------------------
// SVPWM delay line
// Fixed-length shift register that lines up side data with the long path.
// ----------------------------------------------------------------------------
module svpwm_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);
  import svpwm_pkg::*;

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// ===== hdl/svpwm_duty_calculator_unit.sv =====
// ----------------------------------------------------------------------------
// SVPWM duty calculator
// Seven-segment space vector PWM: angle and d/q commands to three counts.
// ----------------------------------------------------------------------------
// Fully pipelined: a request is taken in every cycle in which start is high
// and busy is low (busy only follows reset), and its result appears on done
// and result, one per request, in order. The latency is set by the
// magnitude path: the input stages, 32 square root cells, one per root
// digit, then 30 restoring divider cells, one per quotient bit, and four
// output stages. The sine path (x^2 then five Taylor cells of two stages
// each) runs alongside and is held in a delay line until the depth is
// ready. The receiver cannot stall; every result is shown for one cycle.
// The user must write the bus voltage and the counter period over the
// plain write port only while no request is in flight; the block does not
// enforce this. No clearing pass after reset.
// ----------------------------------------------------------------------------
module svpwm_duty_calculator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  svpwm_pkg::svpwm_req_t               request,
  output logic                                done,
  output svpwm_pkg::svpwm_res_t               result,
  input  logic                                cfg_we,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [svpwm_pkg::CFG_W-1:0]         cfg_wdata
);
  import svpwm_pkg::*;

  localparam logic [ANGLE_BITS-1:0] QUARTER  = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS:0]   TURN     = (ANGLE_BITS + 1)'(1) << ANGLE_BITS;
  localparam logic [X_W-1:0]        ONE_Q30  = X_W'(1) << Q30_BITS;
  localparam int                    TSEL_LSB = Q30_BITS - DUTY_BITS;
  localparam int                    TSEL_W   = T_W - TSEL_LSB;
  localparam int                    CPROD_W  = TSEL_W + PERIOD_W;

  // Configuration registers
  logic [BV_W-1:0]     bus_voltage;
  logic [PERIOD_W-1:0] period_top;
  logic [BVSQ_W-1:0]   bv_sq;

  // Valid shift line: one bit per pipeline stage
  logic [PIPE_DEPTH-1:0] vld;
  logic                  accept;

  // Stage 1: captured request
  svpwm_req_t req_q;

  // Magnitude path
  logic [SQ_W-1:0]         sq_d, sq_q;
  logic signed [2*VOLT_W-1:0] pd, pq;
  logic [THREE_W-1:0]      three;
  root_pipe_t              root_bus [ROOT_CELLS+1];
  div_pipe_t               div_bus  [DIV_CELLS+1];
  logic [X_W-1:0]          k_depth;

  // Angle path
  logic [ANGLE_BITS-1:0]    ang, theta;
  logic [ANGLE_BITS+2:0]    u;
  sector_t                  sect_a;
  logic [SECT_W-1:0]        sect_dly;
  logic [ANGLE_BITS-1:0]    r_a;
  logic [ANGLE_BITS+X_W-1:0]   p2;
  logic [ANGLE_BITS+X_W:0]     p1;
  logic [X_W-1:0]           a1, a2;
  logic [2*X_W-1:0]         sq_a1, sq_a2;
  sin_pipe_t                sin1_bus [SIN_TERMS+1];
  sin_pipe_t                sin2_bus [SIN_TERMS+1];
  logic [X_W-1:0]           sin1, sin2, sin1_dly, sin2_dly;
  logic [SECT_W-1:0]        sect_raw;

  // Output stages
  logic [T_W-1:0]     t1, t2, ta, tb, tc, tsum, t0, th;
  sector_t            sect_t, sect_p, sect_c;
  logic [2*X_W-1:0]   pk1, pk2;
  logic [CPROD_W-1:0] ca, cb, cc;
  logic [CPROD_W-1:0] qa, qb, qc;

  assign accept = start && !busy;
  assign busy   = rst;
  assign done   = vld[PIPE_DEPTH-1];

  // Register writes; out-of-range indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_voltage <= BUS_VOLTAGE_RESET;
      period_top  <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_BUS_VOLTAGE: bus_voltage <= cfg_wdata[BV_W-1:0];
        REG_PERIOD:      period_top  <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared bus voltage for the clamp test; settles long before use
  always_ff @(posedge clk) begin
    bv_sq <= bus_voltage * bus_voltage;
  end

  // Advance the valid line every cycle; nothing ever stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  // Stage 1: hold the request
  always_ff @(posedge clk) begin
    req_q <= request;
  end

  // ---------------- Magnitude: sqrt(3 (d^2 + q^2)) / Vbus in Q30 ----------

  assign pd = req_q.volt_d * req_q.volt_d;
  assign pq = req_q.volt_q * req_q.volt_q;

  // Stage 2: squares
  always_ff @(posedge clk) begin
    sq_d <= pd[SQ_W-1:0];
    sq_q <= pq[SQ_W-1:0];
  end

  assign three = THREE_W'(3) * (THREE_W'(sq_d) + THREE_W'(sq_q));

  // Stage 3: clamp test and radicand (3S in Q32) into the root chain.
  // A zero bus voltage always clamps, so the result never uses a zero divide.
  always_ff @(posedge clk) begin
    root_bus[0].clamp <= three >= THREE_W'(bv_sq);
    root_bus[0].v     <= {three[ROOT_IN_W-33:0], 32'b0};
    root_bus[0].res   <= '0;
  end

  // One root cell per result digit, most significant first
  for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_root
    svpwm_root_cell #(.IDX(i)) u_root (
      .clk  (clk),
      .din  (root_bus[i]),
      .dout (root_bus[i+1])
    );
  end

  // Root has 16 fraction bits; shift up to Q30 before dividing by Vbus
  assign div_bus[0].rem   =
    DIV_W'(root_bus[ROOT_CELLS].res[ROOT_OUT_W-1:0]) << ROOT_SHIFT;
  assign div_bus[0].quo   = '0;
  assign div_bus[0].clamp = root_bus[ROOT_CELLS].clamp;

  // One divider cell per quotient bit, most significant first
  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    svpwm_div_cell #(.IDX(DIV_CELLS - 1 - j)) u_div (
      .clk     (clk),
      .divisor (bus_voltage),
      .din     (div_bus[j]),
      .dout    (div_bus[j+1])
    );
  end

  // Depth times sqrt3, saturated to one when over the hexagon limit
  assign k_depth = div_bus[DIV_CELLS].clamp ? ONE_Q30 : X_W'(div_bus[DIV_CELLS].quo);

  // ---------------- Angle: sector and in-sector sine arguments -----------

  // Rotate by a quarter turn: forward when Uq is positive, back otherwise
  assign ang   = ANGLE_BITS'({req_q.elec_angle, 24'b0} >> (40 - ANGLE_BITS));
  assign theta = (req_q.volt_q > 0) ? ang + QUARTER : ang - QUARTER;
  assign u     = (ANGLE_BITS + 3)'(theta) * (ANGLE_BITS + 3)'(6);
  assign sect_raw = u[ANGLE_BITS+2:ANGLE_BITS];

  // Stage 2: sector and position within the sector
  always_ff @(posedge clk) begin
    sect_a <= sector_t'(sect_raw);
    r_a    <= u[ANGLE_BITS-1:0];
  end

  assign p2 = (ANGLE_BITS + X_W)'(r_a) * (ANGLE_BITS + X_W)'(PI3_Q30);
  assign p1 = (ANGLE_BITS + X_W + 1)'(TURN - (ANGLE_BITS + 1)'(r_a))
            * (ANGLE_BITS + X_W + 1)'(PI3_Q30);

  // Stage 3: arguments in radians, Q30
  always_ff @(posedge clk) begin
    a2 <= X_W'(p2 >> ANGLE_BITS);
    a1 <= X_W'(p1 >> ANGLE_BITS);
  end

  assign sq_a1 = a1 * a1;
  assign sq_a2 = a2 * a2;

  // Stage 4: seed both series with x and x^2
  always_ff @(posedge clk) begin
    sin1_bus[0].term <= a1;
    sin1_bus[0].x2   <= X_W'(sq_a1 >> Q30_BITS);
    sin1_bus[0].sum  <= $signed(SUM_W'(a1));
    sin2_bus[0].term <= a2;
    sin2_bus[0].x2   <= X_W'(sq_a2 >> Q30_BITS);
    sin2_bus[0].sum  <= $signed(SUM_W'(a2));
  end

  for (genvar n = 0; n < SIN_TERMS; n++) begin : g_sin
    svpwm_sin_cell #(.N(n + 1)) u_sin1 (
      .clk  (clk),
      .din  (sin1_bus[n]),
      .dout (sin1_bus[n+1])
    );
    svpwm_sin_cell #(.N(n + 1)) u_sin2 (
      .clk  (clk),
      .din  (sin2_bus[n]),
      .dout (sin2_bus[n+1])
    );
  end

  // Floor negative sums at zero
  assign sin1 = sin1_bus[SIN_TERMS].sum[SUM_W-1] ? '0 : sin1_bus[SIN_TERMS].sum[X_W-1:0];
  assign sin2 = sin2_bus[SIN_TERMS].sum[SUM_W-1] ? '0 : sin2_bus[SIN_TERMS].sum[X_W-1:0];

  // Hold sines and sector until the depth comes out of the divider
  svpwm_delay #(.WIDTH(2 * X_W), .DEPTH(ALIGN_DEPTH)) u_sin_dly (
    .clk  (clk),
    .din  ({sin1, sin2}),
    .dout ({sin1_dly, sin2_dly})
  );

  svpwm_delay #(.WIDTH(SECT_W), .DEPTH(SECT_DEPTH)) u_sect_dly (
    .clk  (clk),
    .din  (sect_a),
    .dout (sect_dly)
  );

  // ---------------- Dwell times and compare counts -----------------------

  assign pk1 = k_depth * sin1_dly;
  assign pk2 = k_depth * sin2_dly;

  // T1 and T2
  always_ff @(posedge clk) begin
    t1     <= T_W'(pk1 >> Q30_BITS);
    t2     <= T_W'(pk2 >> Q30_BITS);
    sect_t <= sector_t'(sect_dly);
  end

  assign tsum = t1 + t2;
  assign t0   = (tsum >= T_W'(ONE_Q30)) ? '0 : T_W'(ONE_Q30) - tsum;
  assign th   = t0 >> 1;

  // Phase on-times per sector, centered by half the zero time
  always_ff @(posedge clk) begin
    sect_p <= sect_t;
    case (sect_t)
      SECT_1: begin
        ta <= tsum + th; tb <= t2 + th; tc <= th;
      end
      SECT_2: begin
        ta <= t1 + th; tb <= tsum + th; tc <= th;
      end
      SECT_3: begin
        ta <= th; tb <= tsum + th; tc <= t2 + th;
      end
      SECT_4: begin
        ta <= th; tb <= t1 + th; tc <= tsum + th;
      end
      SECT_5: begin
        ta <= t2 + th; tb <= th; tc <= tsum + th;
      end
      default: begin
        ta <= tsum + th; tb <= th; tc <= t1 + th;
      end
    endcase
  end

  // Scale by the period
  always_ff @(posedge clk) begin
    sect_c <= sect_p;
    ca <= CPROD_W'(ta[T_W-1:TSEL_LSB]) * CPROD_W'(period_top);
    cb <= CPROD_W'(tb[T_W-1:TSEL_LSB]) * CPROD_W'(period_top);
    cc <= CPROD_W'(tc[T_W-1:TSEL_LSB]) * CPROD_W'(period_top);
  end

  assign qa = ca >> DUTY_BITS;
  assign qb = cb >> DUTY_BITS;
  assign qc = cc >> DUTY_BITS;

  // Saturate at the period and drive the result
  always_ff @(posedge clk) begin
    result.duty_a     <= (qa > CPROD_W'(period_top)) ? period_top : qa[DUTY_W-1:0];
    result.duty_b     <= (qb > CPROD_W'(period_top)) ? period_top : qb[DUTY_W-1:0];
    result.duty_c     <= (qc > CPROD_W'(period_top)) ? period_top : qc[DUTY_W-1:0];
    result.sector_num <= SECT_W'(sect_c) + SECT_W'(1);
  end

endmodule

// ===== hdl/svpwm_checker.sv =====
// ----------------------------------------------------------------------------
// SVPWM duty calculator checker
// Port-level assertions on latency, sector range and duty bounds.
// ----------------------------------------------------------------------------
module svpwm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input svpwm_pkg::svpwm_req_t           request,
  input logic                            done,
  input svpwm_pkg::svpwm_res_t           result,
  input logic                            cfg_we,
  input logic [svpwm_pkg::CFG_IDX_W-1:0] cfg_addr,
  input logic [svpwm_pkg::CFG_W-1:0]     cfg_wdata
);
  import svpwm_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [PERIOD_W-1:0] period_sh;
  logic [CNT_W-1:0]    warm;

  // Track the period as written through the port
  always_ff @(posedge clk) begin
    if (rst) begin
      period_sh <= PERIOD_RESET;
    end else if (cfg_we && cfg_addr == REG_PERIOD) begin
      period_sh <= cfg_wdata[PERIOD_W-1:0];
    end
  end

  // Cycles since reset, saturating once the pipeline has filled
  always_ff @(posedge clk) begin
    if (rst) begin
      warm <= '0;
    end else if (warm != CNT_W'(PIPE_DEPTH)) begin
      warm <= warm + CNT_W'(1);
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (warm >= CNT_W'(PIPE_DEPTH - 1)) |-> (done == $past(start && !busy, PIPE_DEPTH)))
    else $error("result strobe does not match request accepted PIPE_DEPTH cycles earlier");

  a_sector: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.sector_num >= 3'd1 && result.sector_num <= 3'd6))
    else $error("sector number out of range");

  a_duty: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.duty_a <= period_sh && result.duty_b <= period_sh
              && result.duty_c <= period_sh))
    else $error("duty count above the PWM period");

  a_zero_period: assert property (@(posedge clk) disable iff (rst)
    (done && period_sh == '0) |->
      (result.duty_a == '0 && result.duty_b == '0 && result.duty_c == '0))
    else $error("nonzero duty with zero period");

endmodule

bind svpwm_duty_calculator_unit svpwm_checker u_svpwm_checker (.*);

// ===== bench/svpwm_duty_calculator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SVPWM duty calculator testbench
// Drives angle and d/q requests under several bus voltage and period settings
// and checks every result against a bit-exact fixed-point duty predictor.
// ----------------------------------------------------------------------------
module svpwm_duty_calculator_unit_tb;
  import svpwm_pkg::*;

  localparam int PHASES = 6;
  localparam int LATENCY = PIPE_DEPTH;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  svpwm_req_t request;
  logic       done;
  svpwm_res_t result;
  logic       cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  svpwm_duty_calculator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor's own copy of the registers
  logic [BV_W-1:0]     model_bus;
  logic [PERIOD_W-1:0] model_period;

  svpwm_req_t pending_reqs[$];
  svpwm_res_t expected_duties[$];
  int  errors = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  gap_left;

  logic [15:0] bus_set[PHASES]    = '{16'd16384, 16'd1, 16'd32767, 16'd0,
                                      16'd4000, 16'hFFFF};
  logic [15:0] period_set[PHASES] = '{16'd3600, 16'd65535, 16'd1, 16'd0,
                                      16'd1000, 16'd40000};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Integer square root, digit by digit
  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Taylor sine to x^11, Q30 in and out
  function automatic logic [63:0] sine_q30(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      term = (term * x2) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return acc < 0 ? 64'd0 : 64'(acc);
  endfunction

  function automatic logic [DUTY_W-1:0] phase_count(logic [63:0] tq);
    logic [63:0] t;
    logic [63:0] c;
    t = tq >> (30 - DUTY_BITS);
    c = (t * model_period) >> DUTY_BITS;
    return c > model_period ? model_period : c[DUTY_W-1:0];
  endfunction

  function automatic svpwm_res_t predict_duties(svpwm_req_t rq);
    logic [63:0] turn, quarter, theta, u, s, r, a1, a2, sq, three, k;
    logic [63:0] t1, t2, tsum, h, ta, tb, tc;
    longint      vd, vq;
    svpwm_res_t  o;
    turn = 64'd1 << ANGLE_BITS;
    quarter = turn >> 2;
    vd = longint'(rq.volt_d);
    vq = longint'(rq.volt_q);
    // Rotate forward on positive q, back otherwise (zero q included)
    if (vq > 0) theta = (rq.elec_angle + quarter) % turn;
    else theta = (rq.elec_angle + turn - quarter) % turn;
    u = theta * 6;
    s = u >> ANGLE_BITS;
    r = u % turn;
    a2 = (r * 64'(PI3_Q30)) >> ANGLE_BITS;
    a1 = ((turn - r) * 64'(PI3_Q30)) >> ANGLE_BITS;
    sq = 64'(vd * vd) + 64'(vq * vq);
    three = 3 * sq;
    // Clamp to full depth; a zero bus always clamps
    if (three >= 64'(model_bus) * 64'(model_bus)) k = 64'd1 << 30;
    else k = (root64(three << 32) << 14) / model_bus;
    t1 = (k * sine_q30(a1)) >> 30;
    t2 = (k * sine_q30(a2)) >> 30;
    tsum = t1 + t2;
    h = (tsum >= (64'd1 << 30) ? 64'd0 : (64'd1 << 30) - tsum) >> 1;
    case (s)
      0: begin ta = t1 + t2 + h; tb = t2 + h; tc = h; end
      1: begin ta = t1 + h; tb = t1 + t2 + h; tc = h; end
      2: begin ta = h; tb = t1 + t2 + h; tc = t2 + h; end
      3: begin ta = h; tb = t1 + h; tc = t1 + t2 + h; end
      4: begin ta = t2 + h; tb = h; tc = t1 + t2 + h; end
      default: begin ta = t1 + t2 + h; tb = h; tc = t1 + h; end
    endcase
    o.duty_a = phase_count(ta);
    o.duty_b = phase_count(tb);
    o.duty_c = phase_count(tc);
    o.sector_num = SECT_W'(s + 1);
    return o;
  endfunction

  // Driver: pop pending requests, hold start until accepted, then draw a gap
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      request <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_duties.push_back(predict_duties(request));
        n_accepted <= n_accepted + 1;
      end
      if (start && busy) begin
        // hold the request
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        request <= pending_reqs.pop_front();
        start <= 1'b1;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    svpwm_res_t want;
    if (!rst && done) begin
      if (expected_duties.size() == 0) begin
        $error("result with nothing expected: %h", result);
        errors++;
      end else begin
        want = expected_duties.pop_front();
        n_checked++;
        if (result.duty_a !== want.duty_a) begin
          $error("duty_a expected %0d actual %0d", want.duty_a, result.duty_a);
          errors++;
        end
        if (result.duty_b !== want.duty_b) begin
          $error("duty_b expected %0d actual %0d", want.duty_b, result.duty_b);
          errors++;
        end
        if (result.duty_c !== want.duty_c) begin
          $error("duty_c expected %0d actual %0d", want.duty_c, result.duty_c);
          errors++;
        end
        if (result.sector_num !== want.sector_num) begin
          $error("sector_num expected %0d actual %0d",
                 want.sector_num, result.sector_num);
          errors++;
        end
      end
    end
  end

  task automatic queue_req(logic [15:0] ang, logic [15:0] d, logic [15:0] q);
    svpwm_req_t rq;
    rq.elec_angle = ang;
    rq.volt_d = d;
    rq.volt_q = q;
    pending_reqs.push_back(rq);
  endtask

  // Write a register at an idle moment, update the predictor alongside
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BUS_VOLTAGE) model_bus = val[BV_W-1:0];
    else model_period = val;
  endtask

  // Let the pipe drain: all requests sent, all results seen, then settle
  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_duties.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random voltage command: mostly modest magnitudes, some full scale
  function automatic logic [15:0] rand_volt();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_BUS_VOLTAGE;
    cfg_wdata = '0;
    model_bus = BUS_VOLTAGE_RESET;
    model_period = PERIOD_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset registers, field extremes, zero q, sector edges
    queue_req(16'h0000, 16'h0000, 16'h0000);
    queue_req(16'hFFFF, 16'h7FFF, 16'h7FFF);
    queue_req(16'h8000, 16'h8000, 16'h8000);
    queue_req(16'h4000, 16'h0100, 16'h0000);
    queue_req(16'h2AAA, 16'h0000, 16'h0200);
    queue_req(16'h2AAB, 16'hFF00, 16'hFE00);
    queue_req(16'h5555, 16'h1000, 16'h0001);
    queue_req(16'hAAAA, 16'h0800, 16'hFFFF);
    queue_req(16'hD555, 16'h2000, 16'h2000);
    queue_req(16'h1234, 16'h5555, 16'hAAAA);
    queue_req(16'hEDCB, 16'h00FF, 16'h7F00);
    for (int i = 0; i < 12; i++)
      queue_req(16'(i * 16'h1555), 16'h0400, 16'h0300);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_BUS_VOLTAGE, bus_set[p]);
      write_reg(REG_PERIOD, period_set[p]);
      for (int i = 0; i < 255; i++) begin
        queue_req(16'($urandom_range(0, 65535)), rand_volt(), rand_volt());
        if (pending_reqs.size() > 8)
          while (pending_reqs.size() > 2) @(posedge clk);
      end
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);

    $display("Checked %0d of %0d requests over %0d register settings.",
             n_checked, n_accepted, PHASES + 1);
    if (errors == 0 && expected_duties.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_duties.size() != 0)
        $error("%0d results never arrived", expected_duties.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/svpwm_pkg.sv
hdl/svpwm_root_cell.sv
hdl/svpwm_div_cell.sv
hdl/svpwm_sin_cell.sv
hdl/svpwm_delay.sv
hdl/svpwm_duty_calculator_unit.sv
hdl/svpwm_checker.sv
bench/svpwm_duty_calculator_unit_tb.sv
